>>> hdl/rsp_pkg.sv
`timescale 1ns / 1ps

package rsp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhPath   = 2'd1,
    PhData   = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  // event codes
  localparam logic [2:0] EvHeader = 3'd0;
  localparam logic [2:0] EvPath   = 3'd1;
  localparam logic [2:0] EvData   = 3'd2;
  localparam logic [2:0] EvEnd    = 3'd3;
  localparam logic [2:0] EvError  = 3'd4;

  // sticky error codes
  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrType     = 3'd1;
  localparam logic [2:0] ErrPathLen  = 3'd2;
  localparam logic [2:0] ErrSize     = 3'd3;
  localparam logic [2:0] ErrAfterEnd = 3'd4;

  // record type bytes
  localparam logic [7:0] TypeEnd   = 8'd0;
  localparam logic [7:0] TypeEntry = 8'd1;

  // header byte positions, type byte counted
  localparam logic [4:0] MtimeFirst    = 5'd5;
  localparam logic [4:0] SizeFirst     = 5'd13;
  localparam logic [4:0] PathLenFirst  = 5'd21;
  localparam logic [4:0] FixedHdrBytes = 5'd23;

  localparam logic [31:0] ModeMask = 32'o7777;

  // configuration register indexes
  localparam logic [1:0] CfgMaxPathLen   = 2'd0;
  localparam logic [1:0] CfgMaxEntrySize = 2'd1;

  localparam logic [15:0] MaxPathLenReset   = 16'd4096;
  localparam logic [63:0] MaxEntrySizeReset = 64'd268435456;

endpackage

>>> hdl/record_stream_parser.sv
`timescale 1ns / 1ps

// timing: a result is registered and valid in the cycle after its byte is accepted
// throughput: one byte per cycle; a new byte is taken while the result
//   register drains, limited only by out_stall_i holding a full result register
// reset: config returns to 4096 / 2^28, parser waits for a record type byte,
//   sticky error cleared, result register empty
module record_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  // input stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  byte_value_o,
  output logic        entry_start_o,
  output logic        entry_end_o,
  output logic [11:0] file_mode_o,
  output logic [63:0] mod_time_o,
  output logic [63:0] entry_size_o,
  output logic [15:0] path_length_o,
  output logic [2:0]  error_code_o
);

  logic [15:0] max_path_len_q;
  logic [63:0] max_entry_size_q;

  rsp_pkg::phase_e phase_q, phase_d;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d, hdr_cnt_inc;
  logic [31:0] mode_q, mode_d, mode_masked;
  logic [63:0] mtime_q, mtime_d;
  logic [63:0] size_q, size_d;
  logic [15:0] plen_q, plen_d;
  logic [15:0] path_rem_q, path_rem_d;
  logic [63:0] data_rem_q, data_rem_d;
  logic [2:0]  err_q, err_d;

  logic        accept;
  logic        out_valid_q, out_valid_d;

  logic [2:0]  ev;
  logic [7:0]  val;
  logic        start, fin;
  logic [11:0] fmode;
  logic [63:0] fmtime, fsize;
  logic [15:0] fplen;

  logic [2:0]  event_q;
  logic [7:0]  byte_q;
  logic        start_q, end_q;
  logic [11:0] fmode_q;
  logic [63:0] fmtime_q, fsize_q;
  logic [15:0] fplen_q;
  logic [2:0]  errc_q;

  // handshake: take a byte whenever the result register is free or draining
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_path_len_q   <= rsp_pkg::MaxPathLenReset;
      max_entry_size_q <= rsp_pkg::MaxEntrySizeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rsp_pkg::CfgMaxPathLen:   max_path_len_q   <= cfg_wdata_i[15:0];
        rsp_pkg::CfgMaxEntrySize: max_entry_size_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign hdr_cnt_inc = hdr_cnt_q + 5'd1;
  assign mode_masked = mode_q & rsp_pkg::ModeMask;

  // parser next state and result for the byte on the input
  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    mode_d     = mode_q;
    mtime_d    = mtime_q;
    size_d     = size_q;
    plen_d     = plen_q;
    path_rem_d = path_rem_q;
    data_rem_d = data_rem_q;
    err_d      = err_q;
    ev         = rsp_pkg::EvHeader;
    val        = 8'd0;
    start      = 1'b0;
    fin        = 1'b0;
    fmode      = 12'd0;
    fmtime     = 64'd0;
    fsize      = 64'd0;
    fplen      = 16'd0;

    if (err_q != rsp_pkg::ErrNone) begin
      ev = rsp_pkg::EvError;
    end else begin
      case (phase_q)
        rsp_pkg::PhDone: begin
          err_d = rsp_pkg::ErrAfterEnd;
          ev    = rsp_pkg::EvError;
        end
        rsp_pkg::PhHeader: begin
          if (hdr_cnt_q == 5'd0) begin
            if (stream_byte_i == rsp_pkg::TypeEnd) begin
              phase_d = rsp_pkg::PhDone;
              ev      = rsp_pkg::EvEnd;
            end else if (stream_byte_i == rsp_pkg::TypeEntry) begin
              hdr_cnt_d = 5'd1;
            end else begin
              err_d = rsp_pkg::ErrType;
              ev    = rsp_pkg::EvError;
            end
          end else begin
            // big-endian shift into the field for this position
            if (hdr_cnt_q < rsp_pkg::MtimeFirst) begin
              mode_d = {mode_q[23:0], stream_byte_i};
            end else if (hdr_cnt_q < rsp_pkg::SizeFirst) begin
              mtime_d = {mtime_q[55:0], stream_byte_i};
            end else if (hdr_cnt_q < rsp_pkg::PathLenFirst) begin
              size_d = {size_q[55:0], stream_byte_i};
            end else begin
              plen_d = {plen_q[7:0], stream_byte_i};
            end
            hdr_cnt_d = hdr_cnt_inc;
            // path length check on the last fixed header byte
            if (hdr_cnt_inc >= rsp_pkg::FixedHdrBytes) begin
              if (plen_d == 16'd0 || plen_d > max_path_len_q) begin
                err_d = rsp_pkg::ErrPathLen;
                ev    = rsp_pkg::EvError;
              end else begin
                path_rem_d = plen_d;
                phase_d    = rsp_pkg::PhPath;
              end
            end
          end
        end
        rsp_pkg::PhPath: begin
          ev         = rsp_pkg::EvPath;
          val        = stream_byte_i;
          path_rem_d = path_rem_q - 16'd1;
          if (path_rem_d == 16'd0) begin
            if (size_q > max_entry_size_q) begin
              err_d = rsp_pkg::ErrSize;
              ev    = rsp_pkg::EvError;
              val   = 8'd0;
            end else begin
              start     = 1'b1;
              fmode     = mode_masked[11:0];
              fmtime    = mtime_q;
              fsize     = size_q;
              fplen     = plen_q;
              hdr_cnt_d = 5'd0;
              if (size_q == 64'd0) begin
                fin     = 1'b1;
                phase_d = rsp_pkg::PhHeader;
              end else begin
                data_rem_d = size_q;
                phase_d    = rsp_pkg::PhData;
              end
            end
          end
        end
        rsp_pkg::PhData: begin
          ev         = rsp_pkg::EvData;
          val        = stream_byte_i;
          data_rem_d = data_rem_q - 64'd1;
          if (data_rem_d == 64'd0) begin
            fin       = 1'b1;
            hdr_cnt_d = 5'd0;
            phase_d   = rsp_pkg::PhHeader;
          end
        end
        default: ;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rsp_pkg::PhHeader;
      hdr_cnt_q  <= 5'd0;
      mode_q     <= 32'd0;
      mtime_q    <= 64'd0;
      size_q     <= 64'd0;
      plen_q     <= 16'd0;
      path_rem_q <= 16'd0;
      data_rem_q <= 64'd0;
      err_q      <= rsp_pkg::ErrNone;
    end else if (accept) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      mode_q     <= mode_d;
      mtime_q    <= mtime_d;
      size_q     <= size_d;
      plen_q     <= plen_d;
      path_rem_q <= path_rem_d;
      data_rem_q <= data_rem_d;
      err_q      <= err_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on every accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q  <= ev;
      byte_q   <= val;
      start_q  <= start;
      end_q    <= fin;
      fmode_q  <= fmode;
      fmtime_q <= fmtime;
      fsize_q  <= fsize;
      fplen_q  <= fplen;
      errc_q   <= (ev == rsp_pkg::EvError) ? err_d : rsp_pkg::ErrNone;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = event_q;
  assign byte_value_o  = byte_q;
  assign entry_start_o = start_q;
  assign entry_end_o   = end_q;
  assign file_mode_o   = fmode_q;
  assign mod_time_o    = fmtime_q;
  assign entry_size_o  = fsize_q;
  assign path_length_o = fplen_q;
  assign error_code_o  = errc_q;

endmodule
